// File: hdl/nnro_pkg.sv
package nnro_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 30;
    localparam int NUM_ITER     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int ANG_W  = 31;
    localparam int MAG_W  = 29;
    localparam int TRIG_W = 34;
    localparam int PROD_W = 2 * TRIG_W;
    localparam int KEY_W  = TRIG_W + 1;
    localparam int IT_W   = 5;

    localparam logic signed [ANG_W-1:0] HALF_TURN = 31'sd360000000;
    localparam logic signed [ANG_W-1:0] FULL_TURN = 31'sd720000000;
    localparam logic [MAG_W-1:0] HALF_MAG    = 29'd360000000;
    localparam logic [MAG_W-1:0] QUARTER_MAG = 29'd180000000;
    localparam logic signed [TRIG_W-1:0] RAD_SCALE = 34'sd39301321;
    localparam logic signed [TRIG_W-1:0] INV_GAIN  = 34'sd652032874;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 68'sd2097152;

    typedef enum logic [4:0] {
        S_LOAD, S_RDP, S_CAPP, S_RDQ, S_CAPQ,
        S_ANG, S_MZ, S_ZI, S_IT, S_TR,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
        S_SWR, S_SWC, S_SW1, S_SW2,
        S_ORD, S_OLD, S_OWT
    } t_state;

    function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [IT_W-1:0] idx);
        logic signed [TRIG_W-1:0] v;
        unique case (idx)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            5'd24: v = 34'sd64;
            5'd25: v = 34'sd32;
            5'd26: v = 34'sd16;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/nearest_neighbor_route_order_top.sv
// Nearest-neighbor route ordering of latitude/longitude points.
// Input channel (i_valid/o_stall): points in signed microdegrees, one per
// cycle while loading; i_last closes the set. Up to 64 points are kept,
// later ones are dropped, but a dropped last point still closes the set.
// After the last item the block stalls its input and orders the set: the
// first point stays, then the nearest remaining point by haversine key is
// picked for each position, earliest on ties.
// Each key takes four sine/cosine evaluations through one shared
// 16-iteration CORDIC plus four products on the same shared 34x34
// multiplier; the CORDIC is the limiting unit.
// Output channel (o_valid/i_stall): the ordered points, o_last on the
// final one, with o_valid low between items. A stalled item holds; the
// block waits with it. After the final item is taken the input reopens.
// Reset (synchronous, active low) empties the point set and drops any
// pending output.
module nearest_neighbor_route_order_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [nnro_pkg::LAT_W-1:0]   i_lat,
    input  logic signed [nnro_pkg::LON_W-1:0]   i_lon,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [nnro_pkg::LAT_W-1:0]   o_lat,
    output logic signed [nnro_pkg::LON_W-1:0]   o_lon,
    output logic                                o_last
);

    nnro_pkg::t_state r_state, n_state;

    logic signed [nnro_pkg::LAT_W-1:0] lat_mem [nnro_pkg::MAX_POINTS];
    logic signed [nnro_pkg::LON_W-1:0] lon_mem [nnro_pkg::MAX_POINTS];

    logic [nnro_pkg::CNT_W-1:0] r_cnt, r_n, r_i, r_j, r_k, r_best;
    logic [nnro_pkg::IT_W-1:0]  r_it;
    logic [1:0]                 r_aidx;

    logic signed [nnro_pkg::LAT_W-1:0] r_rd_lat, r_plat, r_qlat, r_blat, r_olat;
    logic signed [nnro_pkg::LON_W-1:0] r_rd_lon, r_plon, r_qlon, r_blon, r_olon;
    logic r_ovalid, r_olast;

    logic [nnro_pkg::MAG_W-1:0] r_m;
    logic r_nsin, r_ncos;
    logic signed [nnro_pkg::TRIG_W-1:0] r_x, r_y, r_z;
    logic signed [nnro_pkg::TRIG_W-1:0] r_sa, r_sb, r_c1, r_c2, r_s1, r_s2, r_cc;
    logic signed [nnro_pkg::KEY_W-1:0]  r_bk;
    logic signed [nnro_pkg::PROD_W-1:0] r_prod;

    logic in_acc, last_acc;
    logic [nnro_pkg::CNT_W-1:0] n_first;
    logic rd_en, wr_en;
    logic [nnro_pkg::ADDR_W-1:0] rd_addr, wr_addr;
    logic signed [nnro_pkg::LAT_W-1:0] wr_lat;
    logic signed [nnro_pkg::LON_W-1:0] wr_lon;
    logic signed [nnro_pkg::TRIG_W-1:0] mul_a, mul_b;
    logic signed [nnro_pkg::ANG_W-1:0] ang, ang_r;
    logic [nnro_pkg::MAG_W-1:0] mag, mag_m;
    logic signed [nnro_pkg::TRIG_W-1:0] y_sh, x_sh, atan_v, cos_v, sin_v;
    logic signed [nnro_pkg::PROD_W-1:0] z_sum;
    logic signed [nnro_pkg::KEY_W-1:0] key;
    logic more_j, more_i, last_iter;

    assign in_acc   = i_valid && !o_stall;
    assign last_acc = in_acc && i_last;
    assign n_first  = (r_cnt < nnro_pkg::CNT_W'(nnro_pkg::MAX_POINTS)) ? r_cnt + 1'b1 : r_cnt;
    assign more_j   = (r_j + 1'b1) < r_n;
    assign more_i   = (r_i + 2'd2) < r_n;
    assign last_iter = r_it == nnro_pkg::IT_W'(nnro_pkg::NUM_ITER - 1);

    assign o_stall = r_state != nnro_pkg::S_LOAD;
    assign o_valid = r_ovalid;
    assign o_lat   = r_olat;
    assign o_lon   = r_olon;
    assign o_last  = r_olast;

    // angle selection and reduction into [0, quarter turn]
    always_comb begin
        unique case (r_aidx)
            2'd0: ang = nnro_pkg::ANG_W'(r_plat) - nnro_pkg::ANG_W'(r_qlat);
            2'd1: ang = nnro_pkg::ANG_W'(r_plon) - nnro_pkg::ANG_W'(r_qlon);
            2'd2: ang = nnro_pkg::ANG_W'(r_plat) <<< 1;
            2'd3: ang = nnro_pkg::ANG_W'(r_qlat) <<< 1;
            default: ang = '0;
        endcase
        if (ang >= nnro_pkg::HALF_TURN) begin
            ang_r = ang - nnro_pkg::FULL_TURN;
        end else if (ang < -nnro_pkg::HALF_TURN) begin
            ang_r = ang + nnro_pkg::FULL_TURN;
        end else begin
            ang_r = ang;
        end
        mag   = ang_r[nnro_pkg::ANG_W-1] ? nnro_pkg::MAG_W'(-ang_r) : nnro_pkg::MAG_W'(ang_r);
        mag_m = (mag > nnro_pkg::QUARTER_MAG) ? nnro_pkg::HALF_MAG - mag : mag;
    end

    always_comb begin
        y_sh   = r_y >>> r_it;
        x_sh   = r_x >>> r_it;
        atan_v = nnro_pkg::atan_q30(r_it);
        sin_v  = r_nsin ? -r_y : r_y;
        cos_v  = r_ncos ? -r_x : r_x;
        z_sum  = r_prod + nnro_pkg::ROUND_HALF;
        key    = nnro_pkg::KEY_W'(r_s1) + nnro_pkg::KEY_W'($signed(r_prod[63:30]));
    end

    // shared multiplier operands
    always_comb begin
        unique case (r_state)
            nnro_pkg::S_MZ: begin
                mul_a = $signed({{(nnro_pkg::TRIG_W-nnro_pkg::MAG_W){1'b0}}, r_m});
                mul_b = nnro_pkg::RAD_SCALE;
            end
            nnro_pkg::S_M1: begin mul_a = r_sa; mul_b = r_sa; end
            nnro_pkg::S_M2: begin mul_a = r_sb; mul_b = r_sb; end
            nnro_pkg::S_M3: begin mul_a = r_c1; mul_b = r_c2; end
            nnro_pkg::S_M5: begin mul_a = r_cc; mul_b = r_s2; end
            default:        begin mul_a = '0;   mul_b = '0;   end
        endcase
    end

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_i[nnro_pkg::ADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_cnt[nnro_pkg::ADDR_W-1:0];
        wr_lat  = i_lat;
        wr_lon  = i_lon;
        unique case (r_state)
            nnro_pkg::S_LOAD: wr_en = in_acc && (r_cnt < nnro_pkg::CNT_W'(nnro_pkg::MAX_POINTS));
            nnro_pkg::S_RDP:  rd_en = 1'b1;
            nnro_pkg::S_CAPP, nnro_pkg::S_RDQ: begin
                rd_en   = 1'b1;
                rd_addr = r_j[nnro_pkg::ADDR_W-1:0];
            end
            nnro_pkg::S_SWR: begin
                rd_en   = 1'b1;
                rd_addr = nnro_pkg::ADDR_W'(r_i + 1'b1);
            end
            nnro_pkg::S_SW1: begin
                wr_en   = 1'b1;
                wr_addr = nnro_pkg::ADDR_W'(r_i + 1'b1);
                wr_lat  = r_blat;
                wr_lon  = r_blon;
            end
            nnro_pkg::S_SW2: begin
                wr_en   = 1'b1;
                wr_addr = r_best[nnro_pkg::ADDR_W-1:0];
                wr_lat  = r_rd_lat;
                wr_lon  = r_rd_lon;
            end
            nnro_pkg::S_ORD: begin
                rd_en   = 1'b1;
                rd_addr = r_k[nnro_pkg::ADDR_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            lat_mem[wr_addr] <= wr_lat;
            lon_mem[wr_addr] <= wr_lon;
        end
        if (rd_en) begin
            r_rd_lat <= lat_mem[rd_addr];
            r_rd_lon <= lon_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nnro_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nnro_pkg::S_LOAD: begin
                if (last_acc) begin
                    n_state = (n_first > 1) ? nnro_pkg::S_RDP : nnro_pkg::S_ORD;
                end
            end
            nnro_pkg::S_RDP:  n_state = nnro_pkg::S_CAPP;
            nnro_pkg::S_CAPP: n_state = nnro_pkg::S_CAPQ;
            nnro_pkg::S_RDQ:  n_state = nnro_pkg::S_CAPQ;
            nnro_pkg::S_CAPQ: n_state = nnro_pkg::S_ANG;
            nnro_pkg::S_ANG:  n_state = nnro_pkg::S_MZ;
            nnro_pkg::S_MZ:   n_state = nnro_pkg::S_ZI;
            nnro_pkg::S_ZI:   n_state = nnro_pkg::S_IT;
            nnro_pkg::S_IT:   n_state = last_iter ? nnro_pkg::S_TR : nnro_pkg::S_IT;
            nnro_pkg::S_TR:   n_state = (r_aidx == 2'd3) ? nnro_pkg::S_M1 : nnro_pkg::S_ANG;
            nnro_pkg::S_M1:   n_state = nnro_pkg::S_M2;
            nnro_pkg::S_M2:   n_state = nnro_pkg::S_M3;
            nnro_pkg::S_M3:   n_state = nnro_pkg::S_M4;
            nnro_pkg::S_M4:   n_state = nnro_pkg::S_M5;
            nnro_pkg::S_M5:   n_state = nnro_pkg::S_M6;
            nnro_pkg::S_M6:   n_state = more_j ? nnro_pkg::S_RDQ : nnro_pkg::S_SWR;
            nnro_pkg::S_SWR:  n_state = nnro_pkg::S_SWC;
            nnro_pkg::S_SWC:  n_state = nnro_pkg::S_SW1;
            nnro_pkg::S_SW1:  n_state = nnro_pkg::S_SW2;
            nnro_pkg::S_SW2:  n_state = more_i ? nnro_pkg::S_RDP : nnro_pkg::S_ORD;
            nnro_pkg::S_ORD:  n_state = nnro_pkg::S_OLD;
            nnro_pkg::S_OLD:  n_state = nnro_pkg::S_OWT;
            nnro_pkg::S_OWT: begin
                if (!i_stall) begin
                    n_state = ((r_k + 1'b1) == r_n) ? nnro_pkg::S_LOAD : nnro_pkg::S_ORD;
                end
            end
            default: n_state = nnro_pkg::S_LOAD;
        endcase
    end

    // control counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                nnro_pkg::S_LOAD: begin
                    if (in_acc) begin
                        r_cnt <= n_first;
                    end
                end
                nnro_pkg::S_OLD: r_ovalid <= 1'b1;
                nnro_pkg::S_OWT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        if ((r_k + 1'b1) == r_n) begin
                            r_cnt <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            nnro_pkg::S_LOAD: begin
                r_n <= n_first;
                r_i <= '0;
                r_k <= '0;
            end
            nnro_pkg::S_RDP: r_j <= r_i + 1'b1;
            nnro_pkg::S_CAPP: begin
                r_plat <= r_rd_lat;
                r_plon <= r_rd_lon;
            end
            nnro_pkg::S_CAPQ: begin
                r_qlat <= r_rd_lat;
                r_qlon <= r_rd_lon;
                r_aidx <= 2'd0;
            end
            nnro_pkg::S_ANG: begin
                r_m    <= mag_m;
                r_nsin <= ang_r[nnro_pkg::ANG_W-1];
                r_ncos <= mag > nnro_pkg::QUARTER_MAG;
            end
            nnro_pkg::S_ZI: begin
                r_z  <= $signed(z_sum[55:22]);
                r_x  <= nnro_pkg::INV_GAIN;
                r_y  <= '0;
                r_it <= '0;
            end
            nnro_pkg::S_IT: begin
                if (!r_z[nnro_pkg::TRIG_W-1]) begin
                    r_x <= r_x - y_sh;
                    r_y <= r_y + x_sh;
                    r_z <= r_z - atan_v;
                end else begin
                    r_x <= r_x + y_sh;
                    r_y <= r_y - x_sh;
                    r_z <= r_z + atan_v;
                end
                r_it <= r_it + 1'b1;
            end
            nnro_pkg::S_TR: begin
                unique case (r_aidx)
                    2'd0: r_sa <= sin_v;
                    2'd1: r_sb <= sin_v;
                    2'd2: r_c1 <= cos_v;
                    2'd3: r_c2 <= cos_v;
                    default: ;
                endcase
                r_aidx <= r_aidx + 1'b1;
            end
            nnro_pkg::S_M2: r_s1 <= $signed(r_prod[63:30]);
            nnro_pkg::S_M3: r_s2 <= $signed(r_prod[63:30]);
            nnro_pkg::S_M4: r_cc <= $signed(r_prod[63:30]);
            nnro_pkg::S_M6: begin
                if ((r_j == r_i + 1'b1) || (key < r_bk)) begin
                    r_bk   <= key;
                    r_best <= r_j;
                    r_blat <= r_qlat;
                    r_blon <= r_qlon;
                end
                r_j <= r_j + 1'b1;
            end
            nnro_pkg::S_SW2: r_i <= r_i + 1'b1;
            nnro_pkg::S_OLD: begin
                r_olat  <= r_rd_lat;
                r_olon  <= r_rd_lon;
                r_olast <= (r_k + 1'b1) == r_n;
            end
            nnro_pkg::S_OWT: begin
                if (!i_stall) begin
                    r_k <= r_k + 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: hdl/nnro_checker.sv
module nnro_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              i_last,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [nnro_pkg::LAT_W-1:0] o_lat,
    input logic signed [nnro_pkg::LON_W-1:0] o_lon,
    input logic                              o_last
);

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while an output item is pending");

    a_close_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last) |=> o_stall)
        else $error("input still open after last point");

    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("output item repeated back to back");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_lat) && $stable(o_lon)
            && $stable(o_last)))
        else $error("stalled output item changed");

endmodule

bind nearest_neighbor_route_order_top nnro_checker u_nnro_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_last  (i_last),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_lat   (o_lat),
    .o_lon   (o_lon),
    .o_last  (o_last)
);
